/* design/dle_pkg.sv */
// ----------------------------------------------------------------------------
// dle_pkg: shared types and constants for the dle byte-stuffing deframer
// register indexes, reset values, decode phase and status codes
// ----------------------------------------------------------------------------
`default_nettype none

package dle_pkg;

	// register indexes on the configuration port
	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_HEADER      = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ESCAPE      = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_FOOTER      = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_PASS_HEADER = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_PASS_FOOTER = 3'd4;

	// register reset values
	localparam logic [7:0] HEADER_RST = 8'd91;
	localparam logic [7:0] ESCAPE_RST = 8'd35;
	localparam logic [7:0] FOOTER_RST = 8'd93;

	// decode phase
	localparam logic [1:0] PHASE_WAIT  = 2'd0;
	localparam logic [1:0] PHASE_FRAME = 2'd1;
	localparam logic [1:0] PHASE_ESC   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_START = 2'd0;
	localparam logic [1:0] ST_BUILD = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;
	localparam logic [1:0] ST_ERROR = 2'd3;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] escape_byte;
		logic [7:0] footer_byte;
		logic       pass_header;
		logic       pass_footer;
	} cfg_t;

	typedef struct packed {
		logic [1:0] status;
		logic       data_valid;
		logic [7:0] payload_byte;
		logic       frame_end;
	} result_t;

endpackage

`default_nettype wire

/* design/dle_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dle_cfg_regs: configuration register bank
// plain indexed write port, out-of-range indexes are ignored
// ----------------------------------------------------------------------------
`default_nettype none

module dle_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [dle_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [7:0]                      cfg_wdata,
	output dle_pkg::cfg_t                        cfg
);

	dle_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte <= dle_pkg::HEADER_RST;
			cfg_q.escape_byte <= dle_pkg::ESCAPE_RST;
			cfg_q.footer_byte <= dle_pkg::FOOTER_RST;
			cfg_q.pass_header <= 1'b0;
			cfg_q.pass_footer <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				dle_pkg::REG_HEADER:      cfg_q.header_byte <= cfg_wdata;
				dle_pkg::REG_ESCAPE:      cfg_q.escape_byte <= cfg_wdata;
				dle_pkg::REG_FOOTER:      cfg_q.footer_byte <= cfg_wdata;
				dle_pkg::REG_PASS_HEADER: cfg_q.pass_header <= cfg_wdata[0];
				dle_pkg::REG_PASS_FOOTER: cfg_q.pass_footer <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* design/dle_decoder.sv */
// ----------------------------------------------------------------------------
// dle_decoder: per-byte unstuffing logic and decode phase register
// phase advances only when the decoded result is taken into the output stage
// ----------------------------------------------------------------------------
`default_nettype none

module dle_decoder (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dle_pkg::cfg_t cfg,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          advance,
	output dle_pkg::result_t   result
);

	logic [1:0] phase_q;
	logic [1:0] phase_d;
	logic [1:0] status;
	logic       valid;
	logic       frame_end;

	always_comb begin
		phase_d   = dle_pkg::PHASE_WAIT;
		status    = dle_pkg::ST_ERROR;
		valid     = 1'b0;
		frame_end = 1'b0;
		unique case (phase_q)
			dle_pkg::PHASE_FRAME: begin
				status = dle_pkg::ST_BUILD;
				// escape test first, so escape wins over footer
				if (rx_byte == cfg.escape_byte) begin
					phase_d = dle_pkg::PHASE_ESC;
				end else if (rx_byte == cfg.footer_byte) begin
					status    = dle_pkg::ST_DONE;
					valid     = cfg.pass_footer;
					frame_end = 1'b1;
					phase_d   = dle_pkg::PHASE_WAIT;
				end else begin
					valid   = 1'b1;
					phase_d = dle_pkg::PHASE_FRAME;
				end
			end
			dle_pkg::PHASE_ESC: begin
				status  = dle_pkg::ST_BUILD;
				valid   = 1'b1;
				phase_d = dle_pkg::PHASE_FRAME;
			end
			default: begin
				// waiting for header, also the unused phase code
				if (rx_byte == cfg.header_byte) begin
					status  = dle_pkg::ST_START;
					valid   = cfg.pass_header;
					phase_d = dle_pkg::PHASE_FRAME;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dle_pkg::PHASE_WAIT;
		end else if (advance) begin
			phase_q <= phase_d;
		end
	end

	assign result.status       = status;
	assign result.data_valid   = valid;
	assign result.payload_byte = valid ? rx_byte : 8'd0;
	assign result.frame_end    = frame_end;

endmodule

`default_nettype wire

/* design/dle_byte_stuffing_deframer.sv */
// ----------------------------------------------------------------------------
// dle_byte_stuffing_deframer: removes header/escape/footer framing from a byte stream
// path: a transferred byte passes the input register, then the result register to the master side
// throughput: one byte per cycle while m_tready does not hold back the result stage, set by
//   the single decode step between the input register and the result register
// reset: arst_n clears both stage valids, the decode phase (waiting for header)
//   and the registers to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module dle_byte_stuffing_deframer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [dle_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [7:0]                     cfg_wdata,

	// slave side: raw stuffed bytes
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,   // [7:0] rx_byte

	// master side: one result per received byte
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [7:0]                          m_tdata,   // [7:0] payload_byte
	output logic [2:0]                          m_tuser,   // [1:0] status, [2] data_valid
	output logic                                m_tlast    // frame_end
);

	dle_pkg::cfg_t    cfg;
	dle_pkg::result_t result;

	// input stage
	logic       vld_s1;
	logic [7:0] byte_s1;

	// result stage
	logic             vld_s2;
	dle_pkg::result_t res_s2;

	logic out_free;
	logic advance;

	dle_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// result stage can load when empty or being drained this cycle
	assign out_free = !vld_s2 || m_tready;
	// input byte is decoded and moved to the result stage
	assign advance  = vld_s1 && out_free;
	// input stage takes a new byte when empty or moving on
	assign s_tready = !vld_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	dle_decoder u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.rx_byte (byte_s1),
		.advance (advance),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_free) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = res_s2.payload_byte;
	assign m_tuser  = {res_s2.data_valid, res_s2.status};
	assign m_tlast  = res_s2.frame_end;

endmodule

`default_nettype wire

/* tb/dle_byte_stuffing_deframer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dle_byte_stuffing_deframer_test: self-checking bench for the byte deframer
// drives raw stuffed bytes on the slave side and checks every result on the
// master side against a cycle-free deframing predictor kept in the bench;
// directed frames first, then random framed traffic under three idle mixes
// ----------------------------------------------------------------------------

module dle_byte_stuffing_deframer_test;

	// no-transfer cycles before the run is declared hung
	localparam int unsigned STALL_LIMIT = 4000;
	// cycles to let the two-stage pipe settle after the last result
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned MAX_REPORTS = 10;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [dle_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [7:0]                     cfg_wdata;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [7:0]                     s_tdata;   // [7:0] rx_byte
	logic                           m_tvalid;
	logic                           m_tready;
	logic [7:0]                     m_tdata;   // [7:0] payload_byte
	logic [2:0]                     m_tuser;   // [1:0] status, [2] data_valid
	logic                           m_tlast;   // frame_end

	dle_byte_stuffing_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// bench copy of the framing registers and the decode phase
	dle_pkg::cfg_t frame_cfg;
	logic [1:0]    pred_phase;

	// deframed results still owed by the block, oldest at the back
	dle_pkg::result_t pending_results[$];

	// idle percentages for the two sides of the handshake
	int unsigned send_idle;
	int unsigned recv_idle;

	// run statistics
	int unsigned bytes_sent;
	int unsigned results_checked;
	int unsigned frames_closed;
	int unsigned header_errors;
	int unsigned mismatch_count;
	int unsigned reg_writes;
	int unsigned settings_used;

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// predictor: one raw byte in, one deframed result out, phase advanced
	// ------------------------------------------------------------------------
	function automatic dle_pkg::result_t deframe_byte(input logic [7:0] b);
		dle_pkg::result_t r;
		r = '0;
		case (pred_phase)
			dle_pkg::PHASE_FRAME: begin
				r.status = dle_pkg::ST_BUILD;
				// escape is tested ahead of footer, so escape == footer never closes
				if (b == frame_cfg.escape_byte) begin
					pred_phase = dle_pkg::PHASE_ESC;
				end else if (b == frame_cfg.footer_byte) begin
					r.status     = dle_pkg::ST_DONE;
					r.data_valid = frame_cfg.pass_footer;
					r.frame_end  = 1'b1;
					pred_phase   = dle_pkg::PHASE_WAIT;
				end else begin
					// a header byte inside a frame is just payload
					r.data_valid = 1'b1;
				end
			end
			dle_pkg::PHASE_ESC: begin
				// byte after an escape is literal payload, whatever its value
				r.status     = dle_pkg::ST_BUILD;
				r.data_valid = 1'b1;
				pred_phase   = dle_pkg::PHASE_FRAME;
			end
			default: begin
				// waiting for header, the unused phase code lands here too
				if (b == frame_cfg.header_byte) begin
					r.status     = dle_pkg::ST_START;
					r.data_valid = frame_cfg.pass_header;
					pred_phase   = dle_pkg::PHASE_FRAME;
				end else begin
					r.status     = dle_pkg::ST_ERROR;
					pred_phase   = dle_pkg::PHASE_WAIT;
				end
			end
		endcase
		if (r.data_valid)
			r.payload_byte = b;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// receiver side: random back-pressure, changed on the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// result checker, sampled on the rising edge
	always @(posedge clk) begin : result_check
		dle_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected result st=%0d dv=%0b pl=%02h end=%0b",
						$realtime, m_tuser[1:0], m_tuser[2], m_tdata, m_tlast);
			end else begin
				want = pending_results.pop_back();
				results_checked++;
				if (want.frame_end)
					frames_closed++;
				if (want.status == dle_pkg::ST_ERROR)
					header_errors++;
				if (m_tuser[1:0] !== want.status || m_tuser[2] !== want.data_valid ||
				    m_tdata !== want.payload_byte || m_tlast !== want.frame_end) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"%0t: result mismatch exp st=%0d dv=%0b pl=%02h end=%0b",
							" got st=%0d dv=%0b pl=%02h end=%0b"},
							$realtime, want.status, want.data_valid, want.payload_byte,
							want.frame_end, m_tuser[1:0], m_tuser[2], m_tdata, m_tlast);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: ends a hung run after too many cycles without any transfer
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
			STALL_LIMIT, pending_results.size());
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// shared driving tasks
	// ------------------------------------------------------------------------

	// one raw byte on the slave side, predicted at the edge it transfers
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_front(deframe_byte(b));
		bytes_sent++;
	endtask

	// stop sending and wait until every owed result has come out
	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only called with the pipe drained
	task automatic write_reg(input logic [dle_pkg::CFG_ADDR_W-1:0] idx,
		input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		// only the low bits a register is wide are kept, other indexes drop
		case (idx)
			dle_pkg::REG_HEADER:      frame_cfg.header_byte = val;
			dle_pkg::REG_ESCAPE:      frame_cfg.escape_byte = val;
			dle_pkg::REG_FOOTER:      frame_cfg.footer_byte = val;
			dle_pkg::REG_PASS_HEADER: frame_cfg.pass_header = val[0];
			dle_pkg::REG_PASS_FOOTER: frame_cfg.pass_footer = val[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// framing code biased toward the byte extremes
	function automatic logic [7:0] pick_code;
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'h00;
		else if (r == 1)
			return 8'hFF;
		else
			return 8'($urandom_range(255));
	endfunction

	// new random setting of all five registers
	task automatic randomize_config;
		logic [7:0] hdr;
		logic [7:0] esc;
		logic [7:0] ftr;
		hdr = pick_code();
		ftr = pick_code();
		esc = pick_code();
		// occasionally make the codes collide
		case ($urandom_range(9))
			0: esc = ftr;
			1: esc = hdr;
			2: ftr = hdr;
			default: ;
		endcase
		drain();
		write_reg(dle_pkg::REG_HEADER, hdr);
		write_reg(dle_pkg::REG_ESCAPE, esc);
		write_reg(dle_pkg::REG_FOOTER, ftr);
		// upper data bits are random and must be dropped by the 1-bit flags
		write_reg(dle_pkg::REG_PASS_HEADER, 8'($urandom_range(255)));
		write_reg(dle_pkg::REG_PASS_FOOTER, 8'($urandom_range(255)));
		settings_used++;
	endtask

	// mostly well-formed stuffed frames, some noise and broken frames
	task automatic send_random_traffic(input int unsigned count);
		int unsigned goal;
		int unsigned len;
		logic [7:0]  v;
		goal = bytes_sent + count;
		while (bytes_sent < goal) begin
			if ($urandom_range(99) < 15) begin
				// noise between frames, usually an error status
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom_range(255)));
			end else begin
				send_byte(frame_cfg.header_byte);
				len = $urandom_range(0, 10);
				repeat (len) begin
					case ($urandom_range(9))
						0: v = frame_cfg.escape_byte;
						1: v = frame_cfg.footer_byte;
						2: v = frame_cfg.header_byte;
						default: v = 8'($urandom_range(255));
					endcase
					// stuff special bytes, except for the odd broken frame
					if ((v == frame_cfg.escape_byte || v == frame_cfg.footer_byte) &&
					    $urandom_range(99) >= 5)
						send_byte(frame_cfg.escape_byte);
					send_byte(v);
				end
				// a frame now and then loses its footer
				if ($urandom_range(99) < 90)
					send_byte(frame_cfg.footer_byte);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// test tasks
	// ------------------------------------------------------------------------

	// reset codes: errors outside a frame, header and escapes inside
	task automatic test_reset_framing;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(dle_pkg::FOOTER_RST);
		send_byte(dle_pkg::HEADER_RST);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(dle_pkg::HEADER_RST);
		send_byte(dle_pkg::ESCAPE_RST);
		send_byte(dle_pkg::FOOTER_RST);
		send_byte(dle_pkg::ESCAPE_RST);
		send_byte(dle_pkg::ESCAPE_RST);
		send_byte(dle_pkg::FOOTER_RST);
		drain();
	endtask

	// kept header and footer, extreme code values
	task automatic test_keep_flags;
		write_reg(dle_pkg::REG_HEADER, 8'h00);
		write_reg(dle_pkg::REG_ESCAPE, 8'hFF);
		write_reg(dle_pkg::REG_FOOTER, 8'h80);
		write_reg(dle_pkg::REG_PASS_HEADER, 8'hFF);
		write_reg(dle_pkg::REG_PASS_FOOTER, 8'h03);
		settings_used++;
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h80);
		drain();
	endtask

	// escape equal to footer: the frame can never close
	task automatic test_escape_is_footer;
		write_reg(dle_pkg::REG_HEADER, 8'hFF);
		write_reg(dle_pkg::REG_ESCAPE, 8'h00);
		write_reg(dle_pkg::REG_FOOTER, 8'h00);
		write_reg(dle_pkg::REG_PASS_HEADER, 8'hFE);
		write_reg(dle_pkg::REG_PASS_FOOTER, 8'hFE);
		settings_used++;
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h55);
		drain();
	endtask

	// writes while a frame is open, then writes to unused indexes
	task automatic test_midframe_writes;
		write_reg(dle_pkg::REG_ESCAPE, 8'h10);
		write_reg(dle_pkg::REG_FOOTER, 8'h42);
		settings_used++;
		send_byte(8'h42);
		drain();
		write_reg(3'd5, 8'hAA);
		write_reg(3'd6, 8'hAA);
		write_reg(3'd7, 8'hAA);
		send_byte(8'h42);
		send_byte(8'hFF);
		send_byte(8'h42);
		drain();
	endtask

	// random traffic over three idle mixes and several register settings
	task automatic test_random_traffic;
		for (int mix = 0; mix < 3; mix++) begin
			case (mix)
				0: begin
					send_idle = 32;
					recv_idle = 77;
				end
				1: begin
					send_idle = 77;
					recv_idle = 32;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			repeat (3) begin
				randomize_config();
				send_random_traffic(67);
			end
		end
		drain();
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		bytes_sent      = 0;
		results_checked = 0;
		frames_closed   = 0;
		header_errors   = 0;
		mismatch_count  = 0;
		reg_writes      = 0;
		settings_used   = 1;
		frame_cfg.header_byte = dle_pkg::HEADER_RST;
		frame_cfg.escape_byte = dle_pkg::ESCAPE_RST;
		frame_cfg.footer_byte = dle_pkg::FOOTER_RST;
		frame_cfg.pass_header = 1'b0;
		frame_cfg.pass_footer = 1'b0;
		pred_phase = dle_pkg::PHASE_WAIT;

		// reset held from the start, released on a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part with light idling on both sides, then the random traffic
		send_idle = 20;
		recv_idle = 20;
		test_reset_framing();
		test_keep_flags();
		test_escape_is_footer();
		test_midframe_writes();
		test_random_traffic();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			mismatch_count++;
			$display("%0d results never arrived", pending_results.size());
		end

		$display("covered %0d raw bytes, %0d results checked, %0d frames closed, %0d errors",
			bytes_sent, results_checked, frames_closed, header_errors);
		$display("%0d register writes over %0d settings, %0d mismatches",
			reg_writes, settings_used, mismatch_count);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
